@@ rtl/spim_pkg.sv @@
// ----------------------------------------------------------------------------
// spim_pkg: shared types and constants for the SPI master core
// Holds the command codes, the register indexes, the word layouts and the
// decoded item that moves from the front end to the shift engine.
// ----------------------------------------------------------------------------
package spim_pkg;

    // Command codes on s_tuser
    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_LOAD     = 2'd1;
    localparam logic [1:0] CMD_SELECT   = 2'd2;
    localparam logic [1:0] CMD_DESELECT = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_CLOCK_IDLE_HIGH   = 3'd0;
    localparam logic [2:0] CFG_SAMPLE_FIRST_EDGE = 3'd1;
    localparam logic [2:0] CFG_LSB_FIRST         = 3'd2;
    localparam logic [2:0] CFG_HALF_PERIOD_TICKS = 3'd3;
    localparam logic [2:0] CFG_SELECT_LINE_COUNT = 3'd4;

    localparam int MAX_SELECT_LINES_DEF = 8;
    localparam int SELECT_PINS          = 8;
    localparam int IN_TDATA_W           = 16;
    localparam int OUT_TDATA_W          = 24;
    localparam int CFG_INDEX_W          = 3;
    localparam int CFG_DATA_W           = 8;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // Classified command, as the engine sees it
    typedef enum logic [2:0] {
        KIND_TICK,
        KIND_LOAD,
        KIND_SELECT,
        KIND_DESELECT,
        KIND_BAD_SELECT
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [2:0]  select_index;
        logic [7:0]  send_byte;
        logic        miso_bit;
    } item_t;

    typedef struct packed {
        logic       clock_idle_high;
        logic       sample_first_edge;
        logic       lsb_first;
        logic [7:0] half_period_ticks;
        logic [3:0] select_line_count;
    } cfg_t;

endpackage

@@ rtl/spim_front.sv @@
// ----------------------------------------------------------------------------
// spim_front: input classifier and two-entry word queue
// Decodes each incoming word into a command kind, checks the chip-select
// index against the line count, and buffers the result for the engine.
// ----------------------------------------------------------------------------
module spim_front #(
    parameter int MAX_SELECT_LINES = spim_pkg::MAX_SELECT_LINES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [2:0] select_index, [10:3] send_byte, [11] miso_bit, [15:12] zero
    input  logic [spim_pkg::IN_TDATA_W-1:0] s_tdata,
    // [1:0] cmd
    input  logic [1:0]                      s_tuser,
    input  logic [3:0]                      select_line_count,
    output logic                            q_valid,
    output spim_pkg::item_t                 q_item,
    input  logic                            q_pop
);
    import spim_pkg::*;

    logic [3:0] lines;
    logic       index_ok;
    item_t      in_item;
    logic       push;

    item_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    // Clamp the line count to what the core was built with
    assign lines    = (select_line_count > 4'(MAX_SELECT_LINES))
                      ? 4'(MAX_SELECT_LINES) : select_line_count;
    assign index_ok = ({1'b0, s_tdata[2:0]} < lines);

    always_comb
    begin
        in_item.select_index = s_tdata[2:0];
        in_item.send_byte    = s_tdata[10:3];
        in_item.miso_bit     = s_tdata[11];
        case (s_tuser)
            CMD_TICK:     in_item.kind = KIND_TICK;
            CMD_LOAD:     in_item.kind = KIND_LOAD;
            CMD_SELECT:   in_item.kind = index_ok ? KIND_SELECT : KIND_BAD_SELECT;
            CMD_DESELECT: in_item.kind = index_ok ? KIND_DESELECT : KIND_BAD_SELECT;
            default:      in_item.kind = KIND_TICK;
        endcase
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(q_pop);
        end
    end

    ast_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    ast_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count overflow");

    ast_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2) && !q_pop |=> (count_reg == 2'd2))
        else $error("full queue lost an entry");

endmodule

@@ rtl/spim_engine.sv @@
// ----------------------------------------------------------------------------
// spim_engine: SPI shift engine and result register
// Takes a classified word per cycle unless stalled, steps divider, clock
// phase and shift registers, updates chip-select mask, registers result.
// ----------------------------------------------------------------------------
module spim_engine #(
    parameter int MAX_SELECT_LINES = spim_pkg::MAX_SELECT_LINES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  spim_pkg::cfg_t                   cfg,
    input  logic                             q_valid,
    input  spim_pkg::item_t                  q_item,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [spim_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import spim_pkg::*;

    logic [7:0]                  tx_reg, tx_next;
    logic [7:0]                  rx_reg, rx_next;
    logic [3:0]                  bit_count_reg, bit_count_next;
    logic [7:0]                  div_reg, div_next;
    logic                        phase_reg, phase_next;
    logic                        active_reg, active_next;
    logic [MAX_SELECT_LINES-1:0] mask_reg, mask_next;
    logic                        m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]      m_tdata_reg, m_tdata_next;

    logic [7:0]             half;
    logic [8:0]             div_inc;
    logic                   refused;
    logic                   done;
    logic [7:0]             rx_out;
    logic                   mosi;
    logic [SELECT_PINS-1:0] lines_n;
    logic [3:0]             bit_inc;

    assign q_pop    = q_valid && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign half     = (cfg.half_period_ticks == 8'd0) ? 8'd1 : cfg.half_period_ticks;
    assign div_inc  = {1'b0, div_reg} + 9'd1;
    assign bit_inc  = bit_count_reg + 4'd1;

    always_comb
    begin
        tx_next        = tx_reg;
        rx_next        = rx_reg;
        bit_count_next = bit_count_reg;
        div_next       = div_reg;
        phase_next     = phase_reg;
        active_next    = active_reg;
        mask_next      = mask_reg;
        refused        = 1'b0;
        done           = 1'b0;
        rx_out         = 8'd0;

        // Command first
        case (q_item.kind)
            KIND_LOAD:
            begin
                if (active_reg)
                begin
                    refused = 1'b1;
                end
                else
                begin
                    tx_next        = q_item.send_byte;
                    rx_next        = 8'd0;
                    bit_count_next = 4'd0;
                    div_next       = 8'd0;
                    phase_next     = 1'b0;
                    active_next    = 1'b1;
                end
            end
            KIND_SELECT:
                mask_next = mask_reg & ~(MAX_SELECT_LINES'(1) << q_item.select_index);
            KIND_DESELECT:
                mask_next = mask_reg | (MAX_SELECT_LINES'(1) << q_item.select_index);
            KIND_BAD_SELECT:
                refused = 1'b1;
            default:
                refused = 1'b0;
        endcase

        // Advance only if a transfer ran at the start of this tick
        if (active_reg)
        begin
            div_next = div_inc[7:0];
            if (div_inc >= {1'b0, half})
            begin
                div_next = 8'd0;
                if (!phase_reg)
                begin
                    phase_next = 1'b1;
                    if (cfg.sample_first_edge)
                    begin
                        rx_next = cfg.lsb_first ? {q_item.miso_bit, rx_reg[7:1]}
                                                : {rx_reg[6:0], q_item.miso_bit};
                    end
                    else if (bit_count_reg != 4'd0)
                    begin
                        tx_next = cfg.lsb_first ? {1'b0, tx_reg[7:1]}
                                                : {tx_reg[6:0], 1'b0};
                    end
                end
                else
                begin
                    phase_next = 1'b0;
                    if (cfg.sample_first_edge)
                    begin
                        tx_next = cfg.lsb_first ? {1'b0, tx_reg[7:1]}
                                                : {tx_reg[6:0], 1'b0};
                    end
                    else
                    begin
                        rx_next = cfg.lsb_first ? {q_item.miso_bit, rx_reg[7:1]}
                                                : {rx_reg[6:0], q_item.miso_bit};
                    end
                    bit_count_next = bit_inc;
                    if (bit_inc >= BITS_PER_BYTE)
                    begin
                        active_next    = 1'b0;
                        done           = 1'b1;
                        rx_out         = rx_next;
                        bit_count_next = 4'd0;
                    end
                end
            end
        end

        if (!active_next)
        begin
            phase_next = 1'b0;
        end

        mosi = active_next && (cfg.lsb_first ? tx_next[0] : tx_next[7]);

        lines_n                       = '1;
        lines_n[MAX_SELECT_LINES-1:0] = mask_next;

        m_tdata_next        = '0;
        m_tdata_next[0]     = phase_next ^ cfg.clock_idle_high;
        m_tdata_next[1]     = mosi;
        m_tdata_next[9:2]   = lines_n;
        m_tdata_next[10]    = active_next;
        m_tdata_next[11]    = done;
        m_tdata_next[19:12] = rx_out;
        m_tdata_next[20]    = refused;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            m_tdata_reg <= m_tdata_next;
            tx_reg      <= tx_next;
            rx_reg      <= rx_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_count_reg <= 4'd0;
            div_reg       <= 8'd0;
            phase_reg     <= 1'b0;
            active_reg    <= 1'b0;
            mask_reg      <= '1;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                bit_count_reg <= bit_count_next;
                div_reg       <= div_next;
                phase_reg     <= phase_next;
                active_reg    <= active_next;
                mask_reg      <= mask_next;
                m_tvalid_reg  <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    ast_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && m_tdata_reg[11] |-> !m_tdata_reg[10])
        else $error("done word still flags busy");

    ast_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> !phase_reg && (div_reg == 8'd0))
        else $error("idle engine with clock phase or divider running");

    ast_bit_count: assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg < BITS_PER_BYTE)
        else $error("bit count out of range");

    ast_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && !m_tready |=> $stable(active_reg) && $stable(mask_reg))
        else $error("engine stepped while result stalled");

endmodule

@@ rtl/spi_master_with_chip_select_core.sv @@
// ----------------------------------------------------------------------------
// spi_master_with_chip_select_core: 8-bit SPI master, modes 0 to 3
// Tick-driven SPI master with programmable polarity, phase, bit order,
// half-period divider and active-low chip-select lines.
// ----------------------------------------------------------------------------
// Each input word is one tick of the serial engine and produces exactly one
// output word carrying the SCLK, MOSI and chip-select pin levels, busy, done,
// the received byte (nonzero only on the done word) and a refused flag. The
// core takes one word every cycle for as long as the output side keeps up:
// the front end classifies each word (tick, load, select, deselect, or a
// select or deselect with an index at or above the line count) into a
// two-entry queue, and the shift engine pops one word per cycle, steps
// divider, clock phase and shift registers in that single cycle, and
// registers the result. The engine's step over its state is what sets the
// rate; a word passes through a queue slot and then the result register. A
// stall on the output holds the engine and fills the queue before s_tready
// drops. Write configuration only while the core is idle; the line count is
// clamped to MAX_SELECT_LINES, and lines above it always read as deselected.
// ----------------------------------------------------------------------------
module spi_master_with_chip_select_core #(
    parameter int MAX_SELECT_LINES = spim_pkg::MAX_SELECT_LINES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write port
    input  logic                             wr_en,
    input  logic [spim_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [spim_pkg::CFG_DATA_W-1:0]  wr_data,
    // Input words
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [2:0] select_index, [10:3] send_byte, [11] miso_bit, [15:12] zero
    input  logic [spim_pkg::IN_TDATA_W-1:0]  s_tdata,
    // [1:0] cmd
    input  logic [1:0]                       s_tuser,
    // Result words
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] sclk_level, [1] mosi_level, [9:2] select_lines_n, [10] busy_res,
    // [11] done_res, [19:12] received_byte, [20] refused, [23:21] zero
    output logic [spim_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import spim_pkg::*;

    cfg_t  cfg_reg;
    logic  q_valid;
    item_t q_item;
    logic  q_pop;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clock_idle_high   <= 1'b0;
            cfg_reg.sample_first_edge <= 1'b0;
            cfg_reg.lsb_first         <= 1'b0;
            cfg_reg.half_period_ticks <= 8'd1;
            cfg_reg.select_line_count <= 4'd1;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_CLOCK_IDLE_HIGH:   cfg_reg.clock_idle_high   <= wr_data[0];
                CFG_SAMPLE_FIRST_EDGE: cfg_reg.sample_first_edge <= wr_data[0];
                CFG_LSB_FIRST:         cfg_reg.lsb_first         <= wr_data[0];
                CFG_HALF_PERIOD_TICKS: cfg_reg.half_period_ticks <= wr_data;
                CFG_SELECT_LINE_COUNT: cfg_reg.select_line_count <= wr_data[3:0];
                default:               cfg_reg.lsb_first         <= cfg_reg.lsb_first;
            endcase
        end
    end

    // Front end: classify and queue
    spim_front #(
        .MAX_SELECT_LINES (MAX_SELECT_LINES)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .select_line_count (cfg_reg.select_line_count),
        .q_valid           (q_valid),
        .q_item            (q_item),
        .q_pop             (q_pop)
    );

    // Back end: shift engine and result register
    spim_engine #(
        .MAX_SELECT_LINES (MAX_SELECT_LINES)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
